>>> rtl/g3alu_pkg.sv
`timescale 1ns / 1ps
// Package for the group-3 execute unit: operation codes, the result record
// and the record carried along the divider chain. No dependencies.
package g3alu_pkg;

    localparam logic [2:0] OP_TEST0 = 3'd0;
    localparam logic [2:0] OP_TEST1 = 3'd1;
    localparam logic [2:0] OP_NOT   = 3'd2;
    localparam logic [2:0] OP_NEG   = 3'd3;
    localparam logic [2:0] OP_MUL   = 3'd4;
    localparam logic [2:0] OP_IMUL  = 3'd5;
    localparam logic [2:0] OP_DIV   = 3'd6;
    localparam logic [2:0] OP_IDIV  = 3'd7;

    localparam logic [1:0] FW_NONE  = 2'd0;
    localparam logic [1:0] FW_CO    = 2'd1;
    localparam logic [1:0] FW_ALL   = 2'd2;

    localparam int NUM_CELLS = 16;

    typedef struct packed {
        logic [15:0] dest_value;
        logic        dest_write;
        logic [15:0] new_ax;
        logic [15:0] new_dx;
        logic        divide_fault;
        logic [1:0]  flags_written;
        logic        carry;
        logic        overflow;
        logic        zero;
        logic        sign;
        logic        parity;
        logic        aux_carry;
    } result_t;

    typedef struct packed {
        result_t     res;
        logic        is_div;
        logic        is_sdiv;
        logic        wide;
        logic        qneg;
        logic        rneg;
        logic [15:0] divisor;
    } item_t;

endpackage

>>> rtl/g3alu_prep.sv
`timescale 1ns / 1ps
// Entry stage: test, not, neg and multiply results, and the operand
// magnitudes and early fault check for the divider chain. Uses g3alu_pkg.
module g3alu_prep (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0]            op,
    input  logic                  wide,
    input  logic [15:0]           operand,
    input  logic [15:0]           imm,
    input  logic [15:0]           ax,
    input  logic [15:0]           dx,
    output logic                  out_valid,
    output g3alu_pkg::item_t      out_item,
    output logic [15:0]           out_rem,
    output logic [15:0]           out_lo
);
    import g3alu_pkg::*;

    logic               valid_reg;
    item_t              item_reg, item_next;
    logic [15:0]        rem_reg, rem_next, lo_reg, lo_next;
    logic [15:0]        src, immv, res, nres, bsx, dmag;
    logic [15:0]        ma, mb;
    logic signed [16:0] sa, sb;
    logic signed [33:0] prod;
    logic [31:0]        p, dvd, mag;
    logic               sgn, dneg, bneg, sbit_src;

    always_comb begin
        src  = wide ? operand : {8'h00, operand[7:0]};
        immv = wide ? imm : {8'h00, imm[7:0]};
        sbit_src = wide ? src[15] : src[7];
        nres = (16'h0000 - src) & (wide ? 16'hffff : 16'h00ff);
        ma = wide ? ax : (op == OP_IMUL ? {{8{ax[7]}}, ax[7:0]} : {8'h00, ax[7:0]});
        mb = (op == OP_IMUL && !wide) ? {{8{src[7]}}, src[7:0]} : src;
        sa = (op == OP_IMUL) ? {ma[15], ma} : {1'b0, ma};
        sb = (op == OP_IMUL) ? {mb[15], mb} : {1'b0, mb};
        prod = sa * sb;
        p = prod[31:0];

        sgn  = (op == OP_IDIV);
        dvd  = wide ? {dx, ax} : (sgn ? {{16{ax[15]}}, ax} : {16'h0000, ax});
        dneg = sgn & dvd[31];
        mag  = dneg ? (32'h0 - dvd) : dvd;
        bneg = sgn & sbit_src;
        bsx  = wide ? src : {{8{src[7]}}, src[7:0]};
        dmag = bneg ? (16'h0000 - bsx) : (sgn ? bsx : src);

        res = src & immv;
        item_next = '0;
        item_next.res.new_ax = ax;
        item_next.res.new_dx = dx;
        item_next.wide = wide;
        item_next.divisor = dmag;
        item_next.is_sdiv = sgn;
        item_next.qneg = dneg ^ bneg;
        item_next.rneg = dneg;
        rem_next = wide ? mag[31:16] : 16'h0000;
        lo_next  = mag[15:0];
        case (op)
            OP_TEST0, OP_TEST1: begin
                item_next.res.flags_written = FW_ALL;
                item_next.res.zero   = (res == 16'h0000);
                item_next.res.sign   = wide ? res[15] : res[7];
                item_next.res.parity = ~^res[7:0];
            end
            OP_NOT: begin
                item_next.res.dest_value = ~src & (wide ? 16'hffff : 16'h00ff);
                item_next.res.dest_write = 1'b1;
            end
            OP_NEG: begin
                item_next.res.dest_value = nres;
                item_next.res.dest_write = 1'b1;
                item_next.res.flags_written = FW_ALL;
                item_next.res.carry     = (src != 16'h0000);
                item_next.res.overflow  = (src == (wide ? 16'h8000 : 16'h0080));
                item_next.res.aux_carry = (src[3:0] != 4'h0);
                item_next.res.zero   = (nres == 16'h0000);
                item_next.res.sign   = wide ? nres[15] : nres[7];
                item_next.res.parity = ~^nres[7:0];
            end
            OP_MUL: begin
                item_next.res.flags_written = FW_CO;
                item_next.res.new_ax = p[15:0];
                if (wide) begin
                    item_next.res.new_dx = p[31:16];
                    item_next.res.carry = (p[31:16] != 16'h0000);
                end else begin
                    item_next.res.carry = (p[15:8] != 8'h00);
                end
                item_next.res.overflow = item_next.res.carry;
            end
            OP_IMUL: begin
                item_next.res.flags_written = FW_CO;
                item_next.res.new_ax = p[15:0];
                if (wide) begin
                    item_next.res.new_dx = p[31:16];
                    item_next.res.carry = (p[31:15] != {17{p[15]}});
                end else begin
                    item_next.res.carry = (p[15:7] != {9{p[7]}});
                end
                item_next.res.overflow = item_next.res.carry;
            end
            default: begin
                item_next.is_div = 1'b1;
                item_next.res.divide_fault = (dmag == 16'h0000) ||
                    (wide ? (mag[31:16] >= dmag) : ({8'h00, mag[15:8]} >= dmag));
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
            rem_reg  <= rem_next;
            lo_reg   <= lo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_rem   = rem_reg;
    assign out_lo    = lo_reg;
endmodule

>>> rtl/g3alu_cell.sv
`timescale 1ns / 1ps
// One restoring divide step: develops one quotient bit and passes the item on.
// Uses g3alu_pkg.
module g3alu_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  g3alu_pkg::item_t in_item,
    input  logic [15:0]      in_rem,
    input  logic [15:0]      in_lo,
    output logic             out_valid,
    output g3alu_pkg::item_t out_item,
    output logic [15:0]      out_rem,
    output logic [15:0]      out_lo
);
    import g3alu_pkg::*;

    logic        valid_reg;
    item_t       item_reg;
    logic [15:0] rem_reg, rem_next, lo_reg, lo_next;
    logic [16:0] t, diff;
    logic        ge;

    always_comb begin
        t    = {in_rem, in_lo[15]};
        diff = t - {1'b0, in_item.divisor};
        ge   = (t >= {1'b0, in_item.divisor});
        rem_next = ge ? diff[15:0] : t[15:0];
        lo_next  = {in_lo[14:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= in_item;
            rem_reg  <= rem_next;
            lo_reg   <= lo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_rem   = rem_reg;
    assign out_lo    = lo_reg;
endmodule

>>> rtl/g3alu_post.sv
`timescale 1ns / 1ps
// Exit stage: signs the quotient and remainder, checks the signed range and
// holds the result for the output transfer. Uses g3alu_pkg.
module g3alu_post (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  g3alu_pkg::item_t   in_item,
    input  logic [15:0]        in_rem,
    input  logic [15:0]        in_lo,
    output logic               out_valid,
    output g3alu_pkg::result_t out_res
);
    import g3alu_pkg::*;

    logic        valid_reg;
    result_t     res_reg, res_next;
    logic [15:0] qv, rv, lim;
    logic        range_fault;

    always_comb begin
        qv  = in_item.qneg ? (16'h0000 - in_lo) : in_lo;
        rv  = in_item.rneg ? (16'h0000 - in_rem) : in_rem;
        lim = in_item.wide ? (in_item.qneg ? 16'h8000 : 16'h7fff)
                           : (in_item.qneg ? 16'h0080 : 16'h007f);
        range_fault = in_item.is_sdiv && (in_lo > lim);
        res_next = in_item.res;
        if (in_item.is_div && !in_item.res.divide_fault) begin
            if (range_fault) begin
                res_next.divide_fault = 1'b1;
            end else if (in_item.wide) begin
                res_next.new_ax = qv;
                res_next.new_dx = rv;
            end else begin
                res_next.new_ax = {rv[7:0], qv[7:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
endmodule

>>> rtl/x86_group3_alu_top.sv
`timescale 1ns / 1ps
// Top level of the group-3 execute unit: entry stage, sixteen divide cells
// and exit stage. Uses g3alu_pkg, g3alu_prep, g3alu_cell and g3alu_post.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | op, wide, operand, imm, ax, dx
//  m_      | out       | m_valid / m_ready  | dest, new AX/DX, fault, flags
//
// One item is accepted per cycle while the output is not stalled; each result
// passes in turn through the entry stage, the sixteen divide cells and the exit
// register. Reset clears only the valid bits of the chain.
// The whole chain advances together, so a stalled output holds every stage.
module x86_group3_alu_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic        s_wide,
    input  logic [15:0] s_operand,
    input  logic [15:0] s_imm,
    input  logic [15:0] s_ax,
    input  logic [15:0] s_dx,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_dest_value,
    output logic        m_dest_write,
    output logic [15:0] m_new_ax,
    output logic [15:0] m_new_dx,
    output logic        m_divide_fault,
    output logic [1:0]  m_flags_written,
    output logic        m_carry,
    output logic        m_overflow,
    output logic        m_zero,
    output logic        m_sign,
    output logic        m_parity,
    output logic        m_aux_carry
);
    import g3alu_pkg::*;

    logic        en;
    logic        vld   [NUM_CELLS+1];
    item_t       itm   [NUM_CELLS+1];
    logic [15:0] rem   [NUM_CELLS+1];
    logic [15:0] lo    [NUM_CELLS+1];
    result_t     res;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    g3alu_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .op        (s_op),
        .wide      (s_wide),
        .operand   (s_operand),
        .imm       (s_imm),
        .ax        (s_ax),
        .dx        (s_dx),
        .out_valid (vld[0]),
        .out_item  (itm[0]),
        .out_rem   (rem[0]),
        .out_lo    (lo[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        g3alu_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vld[i]),
            .in_item   (itm[i]),
            .in_rem    (rem[i]),
            .in_lo     (lo[i]),
            .out_valid (vld[i+1]),
            .out_item  (itm[i+1]),
            .out_rem   (rem[i+1]),
            .out_lo    (lo[i+1])
        );
    end

    g3alu_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld[NUM_CELLS]),
        .in_item   (itm[NUM_CELLS]),
        .in_rem    (rem[NUM_CELLS]),
        .in_lo     (lo[NUM_CELLS]),
        .out_valid (m_valid),
        .out_res   (res)
    );

    assign m_dest_value    = res.dest_value;
    assign m_dest_write    = res.dest_write;
    assign m_new_ax        = res.new_ax;
    assign m_new_dx        = res.new_dx;
    assign m_divide_fault  = res.divide_fault;
    assign m_flags_written = res.flags_written;
    assign m_carry         = res.carry;
    assign m_overflow      = res.overflow;
    assign m_zero          = res.zero;
    assign m_sign          = res.sign;
    assign m_parity        = res.parity;
    assign m_aux_carry     = res.aux_carry;

`ifndef ASSERT_OFF
    a_fault_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_fault |-> m_flags_written == FW_NONE && !m_dest_write
            && !m_carry && !m_overflow)
        else $error("divide fault with flags or write-back");
    a_dest_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dest_write |-> m_dest_value == 16'h0000)
        else $error("destination value without write-back");
    a_co_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flags_written == FW_CO |-> !m_zero && !m_sign && !m_parity
            && !m_aux_carry && m_carry == m_overflow)
        else $error("multiply flags inconsistent");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> !s_ready || $past(vld[NUM_CELLS]) == vld[NUM_CELLS])
        else $error("chain moved during stall");
`endif
endmodule

>>> tb/sv/g3alu_checker.sv
`timescale 1ns / 1ps
// Checker for the group-3 execute unit: watches both channels, predicts each
// result from the accepted instruction and compares. Depends on g3alu_pkg.
module g3alu_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [2:0]          s_op,
    input  logic                s_wide,
    input  logic [15:0]         s_operand,
    input  logic [15:0]         s_imm,
    input  logic [15:0]         s_ax,
    input  logic [15:0]         s_dx,
    input  logic                m_valid,
    input  logic                m_ready,
    input  g3alu_pkg::result_t  m_res,
    output int                  fail_count,
    output int                  pending
);
    import g3alu_pkg::*;

    result_t pending_results[$];

    function automatic logic even_parity(logic [15:0] v);
        return ~(^v[7:0]);
    endfunction

    function automatic result_t execute_group3(logic [2:0] op, logic wide,
                                               logic [15:0] opnd, logic [15:0] immv,
                                               logic [15:0] ax, logic [15:0] dx);
        result_t r;
        logic [15:0] mask, sbit, src, res;
        logic [31:0] p;
        longint sa, sb, sp, q, rm, lim, dvd;
        r = '0;
        mask = wide ? 16'hffff : 16'h00ff;
        sbit = wide ? 16'h8000 : 16'h0080;
        src = opnd & mask;
        r.new_ax = ax;
        r.new_dx = dx;
        case (op)
            OP_TEST0, OP_TEST1: begin
                res = src & immv & mask;
                r.flags_written = FW_ALL;
                r.zero = (res == 0);
                r.sign = (res & sbit) != 0;
                r.parity = even_parity(res);
            end
            OP_NOT: begin
                r.dest_value = ~src & mask;
                r.dest_write = 1'b1;
            end
            OP_NEG: begin
                res = (16'd0 - src) & mask;
                r.dest_value = res;
                r.dest_write = 1'b1;
                r.flags_written = FW_ALL;
                r.carry = src != 0;
                r.overflow = src == sbit;
                r.aux_carry = src[3:0] != 0;
                r.zero = res == 0;
                r.sign = (res & sbit) != 0;
                r.parity = even_parity(res);
            end
            OP_MUL: begin
                r.flags_written = FW_CO;
                if (wide) begin
                    p = ax * src;
                    r.new_ax = p[15:0];
                    r.new_dx = p[31:16];
                    r.carry = p[31:16] != 0;
                end else begin
                    p = ax[7:0] * src;
                    r.new_ax = p[15:0];
                    r.carry = p[15:8] != 0;
                end
                r.overflow = r.carry;
            end
            OP_IMUL: begin
                r.flags_written = FW_CO;
                sa = wide ? longint'($signed(ax)) : longint'($signed(ax[7:0]));
                sb = wide ? longint'($signed(src)) : longint'($signed(src[7:0]));
                sp = sa * sb;
                r.new_ax = sp[15:0];
                if (wide) begin
                    r.new_dx = sp[31:16];
                    r.carry = sp < -32768 || sp > 32767;
                end else begin
                    r.carry = sp < -128 || sp > 127;
                end
                r.overflow = r.carry;
            end
            OP_DIV: begin
                dvd = wide ? longint'({dx, ax}) : longint'(ax);
                if (src == 0 || dvd / src > mask) begin
                    r.divide_fault = 1'b1;
                end else begin
                    q = dvd / src;
                    rm = dvd % src;
                    if (wide) begin
                        r.new_ax = q[15:0];
                        r.new_dx = rm[15:0];
                    end else begin
                        r.new_ax = {rm[7:0], q[7:0]};
                    end
                end
            end
            default: begin
                dvd = wide ? longint'($signed({dx, ax})) : longint'($signed(ax));
                sb = wide ? longint'($signed(src)) : longint'($signed(src[7:0]));
                lim = wide ? 32768 : 128;
                if (sb == 0) begin
                    r.divide_fault = 1'b1;
                end else begin
                    q = dvd / sb;
                    rm = dvd % sb;
                    if (q < -lim || q > lim - 1) begin
                        r.divide_fault = 1'b1;
                    end else if (wide) begin
                        r.new_ax = q[15:0];
                        r.new_dx = rm[15:0];
                    end else begin
                        r.new_ax = {rm[7:0], q[7:0]};
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        result_t e;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_results.push_back(execute_group3(s_op, s_wide, s_operand,
                                                         s_imm, s_ax, s_dx));
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    e = pending_results.pop_front();
                    if (m_res.dest_value !== e.dest_value)
                        report_mismatch("dest_value", m_res.dest_value, e.dest_value);
                    if (m_res.dest_write !== e.dest_write)
                        report_mismatch("dest_write", m_res.dest_write, e.dest_write);
                    if (m_res.new_ax !== e.new_ax)
                        report_mismatch("new_ax", m_res.new_ax, e.new_ax);
                    if (m_res.new_dx !== e.new_dx)
                        report_mismatch("new_dx", m_res.new_dx, e.new_dx);
                    if (m_res.divide_fault !== e.divide_fault)
                        report_mismatch("divide_fault", m_res.divide_fault, e.divide_fault);
                    if (m_res.flags_written !== e.flags_written)
                        report_mismatch("flags_written", m_res.flags_written,
                                        e.flags_written);
                    if (m_res.carry !== e.carry)
                        report_mismatch("carry", m_res.carry, e.carry);
                    if (m_res.overflow !== e.overflow)
                        report_mismatch("overflow", m_res.overflow, e.overflow);
                    if (m_res.zero !== e.zero)
                        report_mismatch("zero", m_res.zero, e.zero);
                    if (m_res.sign !== e.sign)
                        report_mismatch("sign", m_res.sign, e.sign);
                    if (m_res.parity !== e.parity)
                        report_mismatch("parity", m_res.parity, e.parity);
                    if (m_res.aux_carry !== e.aux_carry)
                        report_mismatch("aux_carry", m_res.aux_carry, e.aux_carry);
                end
            end
            pending = pending_results.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for x86_group3_alu_top: clock, reset, instruction stimulus,
// result back-pressure and verdict. Uses g3alu_pkg and g3alu_checker.
module tb_top;
    import g3alu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_RANDOM = 600;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_op;
    logic        s_wide;
    logic [15:0] s_operand, s_imm, s_ax, s_dx;
    logic        m_valid;
    logic        m_ready;
    wire result_t m_res;
    int          fail_count, pending, cycles;
    bit          quiet;

    x86_group3_alu_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_wide(s_wide),
        .s_operand(s_operand), .s_imm(s_imm), .s_ax(s_ax), .s_dx(s_dx),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_dest_value(m_res.dest_value), .m_dest_write(m_res.dest_write),
        .m_new_ax(m_res.new_ax), .m_new_dx(m_res.new_dx),
        .m_divide_fault(m_res.divide_fault), .m_flags_written(m_res.flags_written),
        .m_carry(m_res.carry), .m_overflow(m_res.overflow), .m_zero(m_res.zero),
        .m_sign(m_res.sign), .m_parity(m_res.parity), .m_aux_carry(m_res.aux_carry)
    );

    g3alu_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_wide(s_wide),
        .s_operand(s_operand), .s_imm(s_imm), .s_ax(s_ax), .s_dx(s_dx),
        .m_valid(m_valid), .m_ready(m_ready), .m_res(m_res),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
    end

    task automatic send_instr(logic [2:0] op, logic wide, logic [15:0] opnd,
                              logic [15:0] immv, logic [15:0] ax, logic [15:0] dx);
        while (!quiet && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_wide <= wide;
        s_operand <= opnd;
        s_imm <= immv;
        s_ax <= ax;
        s_dx <= dx;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_divide(logic [2:0] op, logic wide);
        logic [15:0] divisor, q, ax, dx;
        logic [31:0] dvd;
        divisor = wide ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 255));
        if ($urandom_range(3) == 0)
            divisor = wide ? 16'($urandom_range(1, 15)) : 16'($urandom_range(1, 7));
        q = wide ? 16'($urandom) : 16'($urandom_range(255));
        if (op == OP_IDIV)
            q = wide ? 16'($urandom_range(32767)) : 16'($urandom_range(127));
        dvd = q * divisor + $urandom_range(divisor - 1);
        if (op == OP_IDIV && $urandom_range(1))
            dvd = -dvd;
        if (op == OP_IDIV && $urandom_range(1))
            divisor = -divisor;
        {dx, ax} = dvd;
        if (!wide)
            dx = 16'($urandom);
        send_instr(op, wide, divisor | (wide ? 16'h0 : 16'($urandom) & 16'hff00),
                   16'($urandom), ax, dx);
    endtask

    initial begin
        logic [2:0] op;
        cycles = 0;
        quiet = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_op = OP_TEST0;
        s_wide = 1'b0;
        s_operand = '0;
        s_imm = '0;
        s_ax = '0;
        s_dx = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_instr(OP_TEST0, 1'b0, 16'h12f0, 16'h340f, 16'h1111, 16'h2222);
        send_instr(OP_TEST1, 1'b1, 16'hffff, 16'h8001, 16'h0, 16'h0);
        send_instr(OP_NOT, 1'b0, 16'hff00, 16'h0, 16'h1234, 16'h5678);
        send_instr(OP_NOT, 1'b1, 16'h0000, 16'hffff, 16'hffff, 16'hffff);
        send_instr(OP_NEG, 1'b0, 16'h0080, 16'h0, 16'h0, 16'h0);
        send_instr(OP_NEG, 1'b1, 16'h8000, 16'h0, 16'h0, 16'h0);
        send_instr(OP_NEG, 1'b1, 16'h0000, 16'h0, 16'h0, 16'h0);
        send_instr(OP_NEG, 1'b0, 16'h0010, 16'h0, 16'h0, 16'h0);
        send_instr(OP_MUL, 1'b0, 16'h00ff, 16'h0, 16'hffff, 16'hbeef);
        send_instr(OP_MUL, 1'b1, 16'hffff, 16'h0, 16'hffff, 16'h0);
        send_instr(OP_MUL, 1'b1, 16'h0002, 16'h0, 16'h7fff, 16'h1234);
        send_instr(OP_IMUL, 1'b0, 16'h0080, 16'h0, 16'h0080, 16'h0);
        send_instr(OP_IMUL, 1'b1, 16'hffff, 16'h0, 16'h8000, 16'h0);
        send_instr(OP_IMUL, 1'b1, 16'h8000, 16'h0, 16'h8000, 16'h0);
        send_instr(OP_DIV, 1'b0, 16'h0000, 16'h0, 16'h1234, 16'h0);
        send_instr(OP_DIV, 1'b0, 16'h0001, 16'h0, 16'h0100, 16'h0);
        send_instr(OP_DIV, 1'b1, 16'hffff, 16'h0, 16'hfffe, 16'hfffe);
        send_instr(OP_DIV, 1'b1, 16'h0001, 16'h0, 16'h0000, 16'h0001);
        send_instr(OP_IDIV, 1'b0, 16'h0000, 16'h0, 16'h0005, 16'h0);
        send_instr(OP_IDIV, 1'b0, 16'h00ff, 16'h0, 16'hff80, 16'h0);
        send_instr(OP_IDIV, 1'b0, 16'h0002, 16'h0, 16'hfff9, 16'h0);
        send_instr(OP_IDIV, 1'b1, 16'hffff, 16'h0, 16'h0000, 16'h8000);
        send_instr(OP_IDIV, 1'b1, 16'hffff, 16'h0, 16'h8000, 16'hffff);
        send_instr(OP_IDIV, 1'b1, 16'h0003, 16'h0, 16'hfff9, 16'hffff);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            quiet = (i >= 200 && i < 300);
            op = 3'($urandom_range(7));
            if (op >= OP_DIV && $urandom_range(3) != 0)
                send_divide(op, 1'($urandom_range(1)));
            else
                send_instr(op, 1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
        end
        s_valid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
